>>> hw/rtl/sensor_health_monitor_defines.svh
// ----------------------------------------------------------------------------
// Sensor health monitor assertion macros
// Shared concurrent check forms used by the monitor RTL.
// ----------------------------------------------------------------------------
`ifndef SENSOR_HEALTH_MONITOR_DEFINES_SVH
`define SENSOR_HEALTH_MONITOR_DEFINES_SVH

// same-cycle implication
`define SHM_ASSERT_NOW(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("sensor health monitor check failed");

// next-cycle implication
`define SHM_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("sensor health monitor check failed");

`endif

>>> hw/rtl/shm_pkg.sv
// ----------------------------------------------------------------------------
// Sensor health monitor package
// Widths, register indexes, status codes and reset values shared by the
// monitor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package shm_pkg;

   localparam int TEMP_W    = 12;
   localparam int MV_W      = 16;
   localparam int PCT_W     = 7;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 16;
   localparam int PROD_W    = 23;
   localparam int SCALED_W  = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_LOW  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_HIGH = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY_MV  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_MV   = 8'd3;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FAILED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_ASLEEP = 2'd3;

   localparam logic signed [TEMP_W-1:0] TEMP_LOW_RST  = -12'sd160;
   localparam logic signed [TEMP_W-1:0] TEMP_HIGH_RST = 12'sd1360;
   localparam logic [MV_W-1:0]          EMPTY_MV_RST  = 16'd2000;
   localparam logic [MV_W-1:0]          FULL_MV_RST   = 16'd4200;

   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
   localparam logic [PCT_W-1:0] PCT_NONE = 7'd0;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temp_low;
      logic signed [TEMP_W-1:0] temp_high;
      logic [MV_W-1:0]          empty_mv;
      logic [MV_W-1:0]          full_mv;
   } csr_type;

   typedef struct packed {
      logic busy;
      logic [PCT_W-1:0] quotient;
   } div_status_type;

endpackage

`default_nettype wire

>>> hw/rtl/shm_csr.sv
// ----------------------------------------------------------------------------
// Sensor health monitor configuration registers
// Temperature window and battery thresholds, written through a plain port.
// ----------------------------------------------------------------------------
`default_nettype none

module shm_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_enable,
   input  wire logic [shm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [shm_pkg::CSR_DAT_W-1:0]   csr_write_data,
   output shm_pkg::csr_type                     csr_regs
);

   shm_pkg::csr_type regs_ff;
   shm_pkg::csr_type regs_in;

   always_comb begin
      regs_in = regs_ff;
      if (csr_write_enable) begin
         case (csr_index)
            shm_pkg::CSR_TEMP_LOW:  regs_in.temp_low  = csr_write_data[shm_pkg::TEMP_W-1:0];
            shm_pkg::CSR_TEMP_HIGH: regs_in.temp_high = csr_write_data[shm_pkg::TEMP_W-1:0];
            shm_pkg::CSR_EMPTY_MV:  regs_in.empty_mv  = csr_write_data[shm_pkg::MV_W-1:0];
            shm_pkg::CSR_FULL_MV:   regs_in.full_mv   = csr_write_data[shm_pkg::MV_W-1:0];
            default: regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.temp_low  <= shm_pkg::TEMP_LOW_RST;
         regs_ff.temp_high <= shm_pkg::TEMP_HIGH_RST;
         regs_ff.empty_mv  <= shm_pkg::EMPTY_MV_RST;
         regs_ff.full_mv   <= shm_pkg::FULL_MV_RST;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign csr_regs = regs_ff;

endmodule

`default_nettype wire

>>> hw/rtl/shm_divider.sv
// ----------------------------------------------------------------------------
// Sensor health monitor percent divider
// Restoring divider, one quotient bit per cycle, for quotients below 128.
// ----------------------------------------------------------------------------
`default_nettype none

module shm_divider (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [shm_pkg::PROD_W-1:0]     dividend,
   input  wire logic [shm_pkg::MV_W-1:0]       divisor,
   output shm_pkg::div_status_type             status
);

   localparam int STEPS = shm_pkg::PCT_W;
   localparam int CNT_W = $clog2(STEPS);

   logic                          busy_ff,  busy_in;
   logic [CNT_W-1:0]              cnt_ff,   cnt_in;
   logic [shm_pkg::PROD_W-1:0]    rem_ff,   rem_in;
   logic [shm_pkg::PROD_W-1:0]    dsh_ff,   dsh_in;
   logic [shm_pkg::PCT_W-1:0]     quo_ff,   quo_in;
   logic [shm_pkg::PROD_W-1:0]    diff;
   logic                          fits;

   assign fits = rem_ff >= dsh_ff;
   assign diff = rem_ff - dsh_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(STEPS - 1);
         rem_in  = dividend;
         dsh_in  = shm_pkg::PROD_W'(divisor) << (STEPS - 1);
         quo_in  = '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = diff;
         end
         quo_in = {quo_ff[shm_pkg::PCT_W-2:0], fits};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   assign status = '{busy: busy_ff, quotient: quo_ff};

endmodule

`default_nettype wire

>>> hw/rtl/sensor_health_monitor.sv
// ----------------------------------------------------------------------------
// Sensor health monitor
// Per-tick temperature window check and tenths conversion, battery percent
// via an iterative divider, and a sticky sleep flag with request pulse.
// ----------------------------------------------------------------------------
//  chan  dir  handshake         payload
//  req   in   req_valid/stall   temp_valid, temp_raw, battery_valid, battery_mv
//  rsp   out  rsp_valid/stall   temp_status, temp_tenths, battery_percent, sleeping, sleep_request
//  csr   in   csr_write_enable  csr_index, csr_write_data
//
//  A request needing the percent division passes through the calc, multiply,
//  divide and done states before the next acceptance; any other request goes
//  from calc straight to done. The divider's seven one-bit steps set the longer path.
//  Reset is synchronous and clears the stored state and the response slot.
//  A stalled response holds in its register; the next request is taken
//  meanwhile and waits at its final step until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sensor_health_monitor_defines.svh"

module sensor_health_monitor (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_stall,
   input  wire logic                                 req_temp_valid,
   input  wire logic signed [shm_pkg::TEMP_W-1:0]    req_temp_raw,
   input  wire logic                                 req_battery_valid,
   input  wire logic [shm_pkg::MV_W-1:0]             req_battery_mv,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   output      logic [shm_pkg::STATUS_W-1:0]         rsp_temp_status,
   output      logic signed [shm_pkg::TEMP_W-1:0]    rsp_temp_tenths,
   output      logic [shm_pkg::PCT_W-1:0]            rsp_battery_percent,
   output      logic                                 rsp_sleeping,
   output      logic                                 rsp_sleep_request,
   input  wire logic                                 csr_write_enable,
   input  wire logic [shm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [shm_pkg::CSR_DAT_W-1:0]        csr_write_data
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CALC = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   shm_pkg::csr_type        regs;
   shm_pkg::div_status_type div_st;

   logic [2:0] state_ff, state_in;

   logic                               tv_ff;
   logic signed [shm_pkg::TEMP_W-1:0]  raw_ff;
   logic                               bv_ff;
   logic [shm_pkg::MV_W-1:0]           mv_ff;

   logic [shm_pkg::STATUS_W-1:0]       status_ff,   status_in;
   logic signed [shm_pkg::TEMP_W-1:0]  tenths_new_ff, tenths_new_in;
   logic                               temp_upd_ff, temp_upd_in;
   logic                               bat_upd_ff,  bat_upd_in;
   logic [shm_pkg::PCT_W-1:0]          pct_new_ff,  pct_new_in;
   logic                               sleep_set_ff, sleep_set_in;
   logic [shm_pkg::MV_W-1:0]           num_ff,      num_in;
   logic [shm_pkg::MV_W-1:0]           den_ff,      den_in;
   logic [shm_pkg::PROD_W-1:0]         prod;

   logic signed [shm_pkg::TEMP_W-1:0]  tenths_ff,   tenths_in;
   logic [shm_pkg::PCT_W-1:0]          pct_ff,      pct_in;
   logic                               sleep_ff,    sleep_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [shm_pkg::STATUS_W-1:0]       rsp_status_ff;
   logic signed [shm_pkg::TEMP_W-1:0]  rsp_tenths_ff;
   logic [shm_pkg::PCT_W-1:0]          rsp_pct_ff;
   logic                               rsp_sleeping_ff;
   logic                               rsp_request_ff;

   logic                               req_take;
   logic                               out_free;
   logic                               finish;
   logic                               div_start;
   logic signed [shm_pkg::SCALED_W-1:0] raw_ext;
   logic signed [shm_pkg::SCALED_W-1:0] scaled;
   logic signed [shm_pkg::SCALED_W-1:0] scaled_adj;
   logic signed [shm_pkg::SCALED_W-1:0] scaled_q;
   logic                               out_of_window;

   shm_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .csr_regs         (regs)
   );

   shm_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod),
      .divisor  (den_ff),
      .status   (div_st)
   );

   assign req_stall = state_ff != S_IDLE;
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign finish    = (state_ff == S_DONE) && out_free;
   assign div_start = state_ff == S_MUL;
   assign prod      = shm_pkg::PROD_W'(num_ff) * shm_pkg::PROD_W'(shm_pkg::PCT_FULL);

   assign raw_ext       = shm_pkg::SCALED_W'(raw_ff);
   assign scaled        = (raw_ext <<< 3) + (raw_ext <<< 1);
   assign scaled_adj    = scaled[shm_pkg::SCALED_W-1] ? scaled + 16'sd15 : scaled;
   assign scaled_q      = scaled_adj >>> 4;
   assign out_of_window = (raw_ff < regs.temp_low) || (raw_ff > regs.temp_high);

   always_comb begin
      state_in      = state_ff;
      status_in     = status_ff;
      tenths_new_in = tenths_new_ff;
      temp_upd_in   = temp_upd_ff;
      bat_upd_in    = bat_upd_ff;
      pct_new_in    = pct_new_ff;
      sleep_set_in  = sleep_set_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            tenths_new_in = scaled_q[shm_pkg::TEMP_W-1:0];
            num_in        = mv_ff - regs.empty_mv;
            den_in        = regs.full_mv - regs.empty_mv;
            temp_upd_in   = 1'b0;
            bat_upd_in    = 1'b0;
            sleep_set_in  = 1'b0;
            pct_new_in    = shm_pkg::PCT_FULL;
            state_in      = S_DONE;
            if (sleep_ff) begin
               status_in = shm_pkg::ST_ASLEEP;
            end else begin
               if (!tv_ff) begin
                  status_in = shm_pkg::ST_FAILED;
               end else if (out_of_window) begin
                  status_in = shm_pkg::ST_RANGE;
               end else begin
                  status_in   = shm_pkg::ST_OK;
                  temp_upd_in = 1'b1;
               end
               if (bv_ff) begin
                  bat_upd_in = 1'b1;
                  if (mv_ff < regs.empty_mv) begin
                     pct_new_in   = shm_pkg::PCT_NONE;
                     sleep_set_in = 1'b1;
                  end else if ((regs.full_mv > regs.empty_mv) &&
                               (num_in < den_in)) begin
                     state_in = S_MUL;
                  end
               end
            end
         end
         S_MUL: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (!div_st.busy) begin
               pct_new_in = div_st.quotient;
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      tenths_in = (finish && temp_upd_ff) ? tenths_new_ff : tenths_ff;
      pct_in    = (finish && bat_upd_ff) ? pct_new_ff : pct_ff;
      sleep_in  = sleep_ff || (finish && sleep_set_ff);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tenths_ff    <= '0;
         pct_ff       <= '0;
         sleep_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tenths_ff    <= tenths_in;
         pct_ff       <= pct_in;
         sleep_ff     <= sleep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take) begin
         tv_ff  <= req_temp_valid;
         raw_ff <= req_temp_raw;
         bv_ff  <= req_battery_valid;
         mv_ff  <= req_battery_mv;
      end
      status_ff     <= status_in;
      tenths_new_ff <= tenths_new_in;
      temp_upd_ff   <= temp_upd_in;
      bat_upd_ff    <= bat_upd_in;
      pct_new_ff    <= pct_new_in;
      sleep_set_ff  <= sleep_set_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      if (finish) begin
         rsp_status_ff   <= status_ff;
         rsp_tenths_ff   <= tenths_in;
         rsp_pct_ff      <= pct_in;
         rsp_sleeping_ff <= sleep_in;
         rsp_request_ff  <= sleep_set_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_temp_status     = rsp_status_ff;
   assign rsp_temp_tenths     = rsp_tenths_ff;
   assign rsp_battery_percent = rsp_pct_ff;
   assign rsp_sleeping        = rsp_sleeping_ff;
   assign rsp_sleep_request   = rsp_request_ff;

   `SHM_ASSERT_NEXT(a_sleep_sticky, clock, reset, sleep_ff, sleep_ff)
   `SHM_ASSERT_NOW(a_request_sleeping, clock, reset, rsp_valid && rsp_sleep_request, rsp_sleeping)
   `SHM_ASSERT_NOW(a_asleep_no_request, clock, reset, rsp_valid && (rsp_temp_status == shm_pkg::ST_ASLEEP), !rsp_sleep_request)
   `SHM_ASSERT_NOW(a_percent_capped, clock, reset, rsp_valid, rsp_battery_percent <= shm_pkg::PCT_FULL)
   `SHM_ASSERT_NOW(a_div_only_in_div, clock, reset, div_st.busy, (state_ff == S_DIV))

endmodule

`default_nettype wire

>>> tb/sensor_health_monitor_test.sv
// ----------------------------------------------------------------------------
// Sensor health monitor testbench
// Drives temperature and battery readings through the request channel with
// random gaps and response stalls, across several register settings, and
// compares every response field against an in-bench prediction of the
// stored temperature, battery percent and sticky sleep flag.
// ----------------------------------------------------------------------------
module sensor_health_monitor_test;
   timeunit 1ns;
   timeprecision 1ps;

   import shm_pkg::*;

   localparam int IDLE_LIMIT    = 5000;
   localparam int SETTLE_CYCLES = 20;
   localparam int REPORT_LIMIT  = 10;
   localparam int PHASE_TICKS   = 200;
   localparam int PHASES        = 8;

   typedef struct {
      logic                     temp_valid;
      logic signed [TEMP_W-1:0] temp_raw;
      logic                     battery_valid;
      logic [MV_W-1:0]          battery_mv;
   } reading_type;

   typedef struct {
      logic [STATUS_W-1:0]      status;
      logic signed [TEMP_W-1:0] tenths;
      logic [PCT_W-1:0]         percent;
      logic                     sleeping;
      logic                     sleep_request;
   } health_type;

   class health_tracker;
      logic signed [TEMP_W-1:0] window_low;
      logic signed [TEMP_W-1:0] window_high;
      logic [MV_W-1:0]          empty_mv;
      logic [MV_W-1:0]          full_mv;
      logic signed [TEMP_W-1:0] kept_tenths;
      logic [PCT_W-1:0]         kept_percent;
      logic                     dozing;
      health_type               owed_reports[$];
      int                       faults;
      int                       checked;

      function new();
         window_low   = TEMP_LOW_RST;
         window_high  = TEMP_HIGH_RST;
         empty_mv     = EMPTY_MV_RST;
         full_mv      = FULL_MV_RST;
         kept_tenths  = '0;
         kept_percent = PCT_NONE;
         dozing       = 1'b0;
         faults       = 0;
         checked      = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index,
                                   logic [CSR_DAT_W-1:0] value);
         case (index)
            CSR_TEMP_LOW:  window_low  = value[TEMP_W-1:0];
            CSR_TEMP_HIGH: window_high = value[TEMP_W-1:0];
            CSR_EMPTY_MV:  empty_mv    = value[MV_W-1:0];
            CSR_FULL_MV:   full_mv     = value[MV_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [PCT_W-1:0] charge_level(logic [MV_W-1:0] mv);
         int unsigned above;
         int unsigned span;
         int unsigned level;
         if (mv < empty_mv) return PCT_NONE;
         if (full_mv <= empty_mv) return PCT_FULL;
         above = mv - empty_mv;
         span  = full_mv - empty_mv;
         level = above * 100 / span;
         return (level > PCT_FULL) ? PCT_FULL : PCT_W'(level);
      endfunction

      function void take_request(reading_type r);
         health_type e;
         int         raw;
         int         low;
         int         high;
         raw  = r.temp_raw;
         low  = window_low;
         high = window_high;
         e.sleep_request = 1'b0;
         if (dozing) begin
            e.status = ST_ASLEEP;
         end else begin
            if (!r.temp_valid) begin
               e.status = ST_FAILED;
            end else if (raw < low || raw > high) begin
               e.status = ST_RANGE;
            end else begin
               kept_tenths = TEMP_W'((raw * 10) / 16);
               e.status    = ST_OK;
            end
            if (r.battery_valid) begin
               kept_percent = charge_level(r.battery_mv);
               if (r.battery_mv < empty_mv) begin
                  dozing          = 1'b1;
                  e.sleep_request = 1'b1;
               end
            end
         end
         e.tenths   = kept_tenths;
         e.percent  = kept_percent;
         e.sleeping = dozing;
         owed_reports.push_back(e);
      endfunction

      function void check_report(health_type got);
         health_type e;
         checked++;
         if (owed_reports.size() == 0) begin
            faults++;
            if (faults <= REPORT_LIMIT)
               $display("response %0d with none outstanding: status %0d tenths %0d",
                        checked, got.status, got.tenths);
            return;
         end
         e = owed_reports.pop_front();
         if (got.status !== e.status || got.tenths !== e.tenths ||
             got.percent !== e.percent || got.sleeping !== e.sleeping ||
             got.sleep_request !== e.sleep_request) begin
            faults++;
            if (faults <= REPORT_LIMIT) begin
               $display("response %0d expected status %0d tenths %0d percent %0d sleep %0b req %0b",
                        checked, e.status, e.tenths, e.percent, e.sleeping, e.sleep_request);
               $display("response %0d actual   status %0d tenths %0d percent %0d sleep %0b req %0b",
                        checked, got.status, got.tenths, got.percent, got.sleeping,
                        got.sleep_request);
            end
         end
      endfunction

      function int pending();
         return owed_reports.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic                     req_temp_valid;
   logic signed [TEMP_W-1:0] req_temp_raw;
   logic                     req_battery_valid;
   logic [MV_W-1:0]          req_battery_mv;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [STATUS_W-1:0]      rsp_temp_status;
   logic signed [TEMP_W-1:0] rsp_temp_tenths;
   logic [PCT_W-1:0]         rsp_battery_percent;
   logic                     rsp_sleeping;
   logic                     rsp_sleep_request;
   logic                     csr_write_enable;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [CSR_DAT_W-1:0]     csr_write_data;

   health_tracker tracker;
   bit            calm;
   int            idle_cycles;

   sensor_health_monitor dut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_temp_valid,
      .req_temp_raw,
      .req_battery_valid,
      .req_battery_mv,
      .rsp_valid,
      .rsp_stall,
      .rsp_temp_status,
      .rsp_temp_tenths,
      .rsp_battery_percent,
      .rsp_sleeping,
      .rsp_sleep_request,
      .csr_write_enable,
      .csr_index,
      .csr_write_data
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic reading_type reading_of(logic tv, int raw, logic bv, int mv);
      reading_type r;
      r.temp_valid    = tv;
      r.temp_raw      = TEMP_W'(raw);
      r.battery_valid = bv;
      r.battery_mv    = MV_W'(mv);
      return r;
   endfunction

   function automatic reading_type random_reading(bit allow_sleep);
      reading_type r;
      int          low;
      int          high;
      int          empty;
      int          full;
      low   = tracker.window_low;
      high  = tracker.window_high;
      empty = tracker.empty_mv;
      full  = tracker.full_mv;
      r.temp_valid = ($urandom_range(0, 6) != 0);
      case ($urandom_range(0, 9))
         0:       r.temp_raw = TEMP_W'(low);
         1:       r.temp_raw = TEMP_W'(low - 1);
         2:       r.temp_raw = TEMP_W'(high);
         3:       r.temp_raw = TEMP_W'(high + 1);
         4:       r.temp_raw = TEMP_W'($urandom);
         default: r.temp_raw = TEMP_W'(int'($urandom_range(0, 2880)) - 880);
      endcase
      r.battery_valid = ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 11))
         0:       r.battery_mv = MV_W'(empty);
         1:       r.battery_mv = MV_W'(empty + 1);
         2:       r.battery_mv = MV_W'(full - 1);
         3:       r.battery_mv = MV_W'(full);
         4:       r.battery_mv = MV_W'(full + 1);
         5:       r.battery_mv = '1;
         default: r.battery_mv = MV_W'($urandom);
      endcase
      // keep the monitor awake unless sleep is wanted
      if (!allow_sleep && r.battery_valid && r.battery_mv < tracker.empty_mv) begin
         if ($urandom_range(0, 1) == 1) r.battery_valid = 1'b0;
         else r.battery_mv = MV_W'($urandom_range(empty, 65535));
      end
      return r;
   endfunction

   task automatic send_reading(input reading_type r);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_temp_valid    <= r.temp_valid;
      req_temp_raw      <= r.temp_raw;
      req_battery_valid <= r.battery_valid;
      req_battery_mv    <= r.battery_mv;
      do @(posedge clock); while (req_stall);
      tracker.take_request(r);
   endtask

   task automatic drain();
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DAT_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      tracker.write_register(index, value);
   endtask

   task automatic set_window(input int low, input int high, input int empty, input int full);
      req_valid <= 1'b0;
      drain();
      write_register(CSR_TEMP_LOW, CSR_DAT_W'(low));
      write_register(CSR_TEMP_HIGH, CSR_DAT_W'(high));
      write_register(CSR_EMPTY_MV, CSR_DAT_W'(empty));
      write_register(CSR_FULL_MV, CSR_DAT_W'(full));
      write_register(CSR_IDX_W'($urandom_range(4, 255)), CSR_DAT_W'($urandom));
      csr_write_enable <= 1'b0;
   endtask

   // count cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("sensor_health_monitor: mismatch");
            $finish;
         end
      end
   end

   initial begin
      int         gap;
      health_type got;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         gap = calm ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         got.status        = rsp_temp_status;
         got.tenths        = rsp_temp_tenths;
         got.percent       = rsp_battery_percent;
         got.sleeping      = rsp_sleeping;
         got.sleep_request = rsp_sleep_request;
         tracker.check_report(got);
      end
   end

   initial begin
      int plan_low[PHASES]   = '{-880, 2000, 100, 0, -160, 0, 0, -880};
      int plan_high[PHASES]  = '{2000, -880, 100, 2000, 1360, 0, 0, 2000};
      int plan_empty[PHASES] = '{0, 1000, 3000, 2500, 2000, 0, 0, 65535};
      int plan_full[PHASES]  = '{65535, 5000, 1000, 2500, 4200, 0, 0, 0};
      tracker = new();
      idle_cycles = 0;
      calm = 1'b0;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_temp_valid    <= 1'b0;
      req_temp_raw      <= '0;
      req_battery_valid <= 1'b0;
      req_battery_mv    <= '0;
      csr_write_enable  <= 1'b0;
      csr_index         <= '0;
      csr_write_data    <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // window and charge edges under reset settings
      send_reading(reading_of(1, 0, 0, 0));
      send_reading(reading_of(1, -160, 1, 4200));
      send_reading(reading_of(1, 1360, 1, 2000));
      send_reading(reading_of(1, -161, 1, 4201));
      send_reading(reading_of(1, 1361, 1, 65535));
      send_reading(reading_of(0, 100, 1, 3100));
      send_reading(reading_of(1, -1, 1, 2001));
      send_reading(reading_of(1, -15, 1, 4199));
      send_reading(reading_of(1, 15, 0, 0));
      send_reading(reading_of(1, -17, 0, 65535));
      send_reading(reading_of(1, -880, 1, 2022));
      send_reading(reading_of(1, 2000, 0, 1));
      send_reading(reading_of(1, -2048, 0, 0));
      send_reading(reading_of(1, 2047, 1, 3000));
      send_reading(reading_of(0, -1, 0, 65535));
      send_reading(reading_of(1, 16, 1, 2000));

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == 5 || phase == 6) begin
            plan_low[phase]   = int'($urandom_range(0, 2880)) - 880;
            plan_high[phase]  = int'($urandom_range(0, 2880)) - 880;
            plan_empty[phase] = $urandom_range(0, 4000);
            plan_full[phase]  = ($urandom_range(0, 1) == 1) ? int'($urandom_range(0, 65535))
                                : plan_empty[phase] + int'($urandom_range(1, 3000));
         end
         set_window(plan_low[phase], plan_high[phase], plan_empty[phase], plan_full[phase]);
         calm = (phase == 2 || phase == 5);
         repeat (PHASE_TICKS) send_reading(random_reading(1'b0));
      end

      // enter sleep, then hold there
      set_window(-160, 1360, 2000, 4200);
      calm = 1'b0;
      repeat (8) send_reading(random_reading(1'b0));
      send_reading(reading_of(1, 400, 1, 1999));
      repeat (15) send_reading(random_reading(1'b1));

      req_valid <= 1'b0;
      drain();
      if (tracker.faults == 0 && tracker.pending() == 0)
         $display("sensor_health_monitor: match");
      else
         $display("sensor_health_monitor: mismatch");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/shm_pkg.sv
hw/rtl/shm_csr.sv
hw/rtl/shm_divider.sv
hw/rtl/sensor_health_monitor.sv
tb/sensor_health_monitor_test.sv
